>>> design/wpsp_pkg.sv
// Shared types and constants for the WAV PCM16 stream parser.
package wpsp_pkg;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       start_of_file;
    } in_t;

    typedef struct packed {
        logic [15:0] sample_value;
        logic [1:0]  status;
        logic        last;
    } out_t;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_INVALID     = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

    localparam logic CFG_RATE = 1'b0;
    localparam logic CFG_FADE = 1'b1;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [5:0] HDR_LAST_POS = 6'd43;
    localparam logic [5:0] HDR_DATA_POS = 6'd40;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_SAMPLES,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK_MUL,
        S_CHK_EVAL,
        S_CHK_END,
        S_MUL1,
        S_MUL2,
        S_DIV,
        S_OUT
    } state_t;

    typedef struct packed {
        logic hdr_byte;
        logic samp_byte;
        logic chk_mul;
        logic chk_eval;
        logic start_samples;
        logic mul1;
        logic mul2;
        logic div_step;
        logic load_ok;
        logic load_err;
        logic adv_index;
    } cmd_t;

    typedef struct packed {
        logic hdr_done;
        logic pair_done;
        logic chk_fail;
        logic div_last;
        logic out_free;
        logic is_last;
    } sts_t;

endpackage

>>> design/wpsp_ctrl.sv
// Controller state machine: parse phase and sequencing of check and fade steps.
module wpsp_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          sof,
    output logic          in_stall,
    input  wpsp_pkg::sts_t sts,
    output wpsp_pkg::cmd_t cmd
);
    import wpsp_pkg::*;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    phase_t eff_phase;
    logic   accept;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign eff_phase = sof ? PH_HEADER : phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_HEADER;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    phase_next = eff_phase;
                    unique case (eff_phase)
                        PH_HEADER:
                        begin
                            cmd.hdr_byte = 1'b1;
                            if (sts.hdr_done)
                                state_next = S_CHK_MUL;
                        end
                        PH_SAMPLES:
                        begin
                            cmd.samp_byte = 1'b1;
                            if (sts.pair_done)
                                state_next = S_MUL1;
                        end
                        default: ;
                    endcase
                end
            end
            S_CHK_MUL:
            begin
                cmd.chk_mul = 1'b1;
                state_next  = S_CHK_EVAL;
            end
            S_CHK_EVAL:
            begin
                cmd.chk_eval = 1'b1;
                state_next   = S_CHK_END;
            end
            S_CHK_END:
            begin
                if (!sts.chk_fail)
                begin
                    cmd.start_samples = 1'b1;
                    phase_next        = PH_SAMPLES;
                    state_next        = S_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.load_err = 1'b1;
                    phase_next   = PH_DONE;
                    state_next   = S_IDLE;
                end
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold the quotient until the output register frees up
                if (sts.out_free)
                begin
                    cmd.load_ok = 1'b1;
                    if (sts.is_last)
                        phase_next = PH_DONE;
                    else
                        cmd.adv_index = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

>>> design/wpsp_dp.sv
// Datapath: header capture, checks, fade multiply and divide, output register.
module wpsp_dp (
    input  logic           clk,
    input  logic           rst_n,
    input  wpsp_pkg::in_t  in_data,
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  logic [31:0]    cfg_wdata,
    input  wpsp_pkg::cmd_t cmd,
    output wpsp_pkg::sts_t sts,
    output logic           out_valid,
    input  logic           out_stall,
    output wpsp_pkg::out_t out_data
);
    import wpsp_pkg::*;

    logic [31:0] rate_reg;
    logic [15:0] fade_reg;
    logic [5:0]  pos_reg, pos_next;
    logic [31:0] shift_reg, shift_next;
    logic [31:0] hdr_mem [10];
    logic [31:0] size_reg;
    logic [31:0] prod_reg;
    logic [1:0]  st_reg;
    logic [30:0] total_reg;
    logic [30:0] index_reg;
    logic [7:0]  low_reg;
    logic [15:0] u_reg;
    logic [31:0] p1_reg;
    logic [31:0] den_reg;
    logic [47:0] rem_reg;
    logic [15:0] q_reg;
    logic [3:0]  k_reg;
    logic        out_valid_reg;
    out_t        out_reg;

    logic [5:0]  eff_pos;
    logic [4:0]  sh;
    logic [31:0] word;
    logic [15:0] bits;
    logic [12:0] bps;
    logic [31:0] size_even;
    logic [15:0] fmt_size_lo;
    logic [1:0]  st_calc;
    logic [15:0] lenv;
    logic [30:0] jval;
    logic        apply_i, apply_j;
    logic [15:0] fi, fj, di, dj;
    logic [47:0] rem_sh;
    logic [31:0] fmt_size;

    assign eff_pos = in_data.start_of_file ? 6'd0 : pos_reg;
    assign sh      = {eff_pos[1:0], 3'b000};
    assign word    = ((eff_pos[1:0] == 2'd0) ? 32'd0 : shift_reg)
                     | ({24'd0, in_data.file_byte} << sh);

    always_comb
    begin
        pos_next   = eff_pos;
        shift_next = in_data.start_of_file ? 32'd0 : shift_reg;
        if (cmd.hdr_byte)
        begin
            if (eff_pos[1:0] != 2'd3)
            begin
                shift_next = word;
                pos_next   = eff_pos + 6'd1;
            end
            else
            begin
                shift_next = 32'd0;
                pos_next   = (eff_pos < HDR_DATA_POS) ? eff_pos + 6'd1 : 6'd0;
            end
        end
        else if (cmd.samp_byte)
            pos_next = eff_pos[0] ? 6'd0 : 6'd1;
    end

    // header checks; the first failing check in this order sets the status
    assign bits      = hdr_mem[8][31:16];
    assign bps       = bits[15:3];
    assign size_even = {size_reg[31:1], 1'b0};
    assign fmt_size  = hdr_mem[4];
    assign fmt_size_lo = fmt_size[15:0];

    always_comb
    begin
        st_calc = ST_OK;
        if (hdr_mem[0] != TAG_RIFF)
            st_calc = ST_INVALID;
        else if (hdr_mem[2] != TAG_WAVE)
            st_calc = ST_INVALID;
        else if (hdr_mem[1] == 32'd0)
            st_calc = ST_INVALID;
        else if (hdr_mem[3] != TAG_FMT)
            st_calc = ST_INVALID;
        else if (fmt_size[31:16] != 16'd0
                 || (fmt_size_lo != 16'd16 && fmt_size_lo != 16'd18
                     && fmt_size_lo != 16'd40))
            st_calc = ST_INVALID;
        else if (hdr_mem[5][31:16] != 16'd1)
            st_calc = ST_UNSUPPORTED;
        else if (hdr_mem[6] != rate_reg)
            st_calc = ST_UNSUPPORTED;
        else if (hdr_mem[7] != prod_reg)
            st_calc = ST_INVALID;
        else if (hdr_mem[9] != TAG_DATA)
            st_calc = ST_INVALID;
        else if (bps != 13'd0 && size_even < {19'd0, bps})
            st_calc = ST_INVALID;
        else if (hdr_mem[5][15:0] != 16'd1)
            st_calc = ST_UNSUPPORTED;
        else if (bits != 16'd16)
            st_calc = ST_INVALID;
    end

    // fade factors
    assign lenv    = (fade_reg == 16'd0) ? 16'd1 : fade_reg;
    assign jval    = total_reg - 31'd1 - index_reg;
    assign apply_i = index_reg <= {15'd0, lenv};
    assign apply_j = jval <= {15'd0, lenv};
    assign fi      = apply_i ? index_reg[15:0] : 16'd1;
    assign di      = apply_i ? lenv : 16'd1;
    assign fj      = apply_j ? jval[15:0] : 16'd1;
    assign dj      = apply_j ? lenv : 16'd1;
    assign rem_sh  = rem_reg >> k_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg      <= 32'd44100;
            fade_reg      <= 16'd500;
            pos_reg       <= 6'd0;
            shift_reg     <= 32'd0;
            index_reg     <= 31'd0;
            total_reg     <= 31'd0;
            low_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
            k_reg         <= 4'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_RATE: rate_reg <= cfg_wdata;
                    CFG_FADE: fade_reg <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (cmd.hdr_byte || cmd.samp_byte)
            begin
                pos_reg   <= pos_next;
                shift_reg <= shift_next;
            end
            if (cmd.samp_byte && !eff_pos[0])
                low_reg <= in_data.file_byte;
            if (cmd.chk_eval)
                total_reg <= size_even[31:1];
            if (cmd.start_samples)
                index_reg <= 31'd0;
            else if (cmd.adv_index)
                index_reg <= index_reg + 31'd1;
            if (cmd.mul2)
                k_reg <= 4'd15;
            else if (cmd.div_step)
                k_reg <= k_reg - 4'd1;
            if (cmd.load_ok || cmd.load_err)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hdr_byte && eff_pos[1:0] == 2'd3)
        begin
            if (eff_pos < HDR_DATA_POS)
                hdr_mem[eff_pos[5:2]] <= word;
            else
                size_reg <= word;
        end
        if (cmd.samp_byte && eff_pos[0])
            u_reg <= {in_data.file_byte ^ 8'h80, low_reg};
        if (cmd.chk_mul)
            prod_reg <= hdr_mem[6] * {19'd0, bps};
        if (cmd.chk_eval)
            st_reg <= st_calc;
        if (cmd.mul1)
        begin
            p1_reg  <= {16'd0, u_reg} * {16'd0, fi};
            den_reg <= {16'd0, di} * {16'd0, dj};
        end
        if (cmd.mul2)
        begin
            rem_reg <= {16'd0, p1_reg} * {32'd0, fj};
            q_reg   <= 16'd0;
        end
        if (cmd.div_step)
        begin
            // restore-free step: subtract the shifted divisor when it fits
            if (rem_sh >= {16'd0, den_reg})
            begin
                rem_reg      <= rem_reg - ({16'd0, den_reg} << k_reg);
                q_reg[k_reg] <= 1'b1;
            end
        end
        if (cmd.load_ok)
        begin
            out_reg.sample_value <= q_reg;
            out_reg.status       <= ST_OK;
            out_reg.last         <= sts.is_last;
        end
        else if (cmd.load_err)
        begin
            out_reg.sample_value <= 16'd0;
            out_reg.status       <= st_reg;
            out_reg.last         <= 1'b1;
        end
    end

    assign sts.hdr_done  = (eff_pos == HDR_LAST_POS);
    assign sts.pair_done = eff_pos[0];
    assign sts.chk_fail  = (st_reg != ST_OK);
    assign sts.div_last  = (k_reg == 4'd0);
    assign sts.out_free  = !out_valid_reg || !out_stall;
    assign sts.is_last   = (index_reg + 31'd1 == total_reg);

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

>>> design/wav_pcm16_stream_parser_top.sv
// Top level of the WAV PCM16 stream parser: controller, datapath and checks.
//
//  channel | signals                         | direction
//  --------+---------------------------------+----------
//  in      | in_valid, in_stall, in_data     | file bytes in
//  out     | out_valid, out_stall, out_data  | samples / errors out
//  cfg     | cfg_we, cfg_index, cfg_wdata    | register writes in
//
// Header bytes and the first byte of each sample are taken without stalling.
// After the header's last byte the input stalls through the rate multiply,
// check and decide states. A sample's second byte stalls it through two
// multiplies and a 16-step shift-subtract divide; a stalled output holds it until it drains.
// Reset is asynchronous; the parser starts at byte 0 of a header.
module wav_pcm16_stream_parser_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  wpsp_pkg::in_t      in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output wpsp_pkg::out_t     out_data,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_wdata
);
    import wpsp_pkg::*;

    cmd_t cmd;
    sts_t sts;

    wpsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sof      (in_data.start_of_file),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    wpsp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status != 2'd3)
        else $error("status code out of range");

    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |-> out_data.last
            && out_data.sample_value == 16'd0)
        else $error("error result not final or nonzero");

    a_single_load: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load_ok && cmd.load_err))
        else $error("two result loads at once");

endmodule
